FILE: rtl/grid_fire_burnout_steps_core_defines.svh
// Assertion helpers for the grid fire burn core
`ifndef GRID_FIRE_BURNOUT_STEPS_CORE_DEFINES_SVH
`define GRID_FIRE_BURNOUT_STEPS_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define GFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gfb_pkg.sv
package gfb_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam int unsigned CfgDataW = 7;
  localparam int unsigned StepsW   = 13;
  localparam logic [StepsW-1:0] STEPS_MAX = 13'd8191;

  // neighbor visit order
  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_CUR,
    S_NBRD,
    S_NBCHK,
    S_LVL,
    S_DONE
  } state_e;

endpackage

FILE: rtl/grid_fire_burnout_steps_core.sv
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// cfg     | cfg_valid_i/ready_o, cfg_index_i, data_i | in
// in      | in_valid_i/ready_o, cell_is_tree_i,      | in
//         | last_cell_i                              |
// out     | out_valid_o/ready_i, burn_steps_o        | out
//
// Load: one cell per cycle into the tree store while idle.
// Burn after the last cell: S_INIT lights column 0 one row at a time, then each
// burned cell passes S_POP and S_CUR, S_NBRD for each direction, S_NBCHK for
// each in-range neighbor, then S_LVL (store and queue: one write, one read port).
// Input is held off from the last cell until the result enters the output
// register; a pending result only stalls the end of the next burn.
// Reset clears control state; store contents are qualified by a fill count.
`include "grid_fire_burnout_steps_core_defines.svh"

module grid_fire_burnout_steps_core #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gfb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gfb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cell_is_tree_i,
  input  logic                          last_cell_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gfb_pkg::StepsW-1:0]    burn_steps_o
);
  import gfb_pkg::*;

  localparam int unsigned Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned LPW   = AW + 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned QW    = AW + CW + RW;
  localparam logic [LPW-1:0] CellsL = LPW'(Cells);
  localparam logic [8:0] MaxW9 = 9'(MAX_WIDTH);
  localparam logic [8:0] MaxH9 = 9'(MAX_HEIGHT);

  state_e state_q, state_d;

  logic [CfgDataW-1:0] cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic [8:0]          w_q, w_d, h_q, h_d;
  logic [LPW-1:0]      pos_q, pos_d, fill_q, fill_d;
  logic [LPW-1:0]      head_q, head_d, tail_q, tail_d, lvl_q, lvl_d;
  logic [RW-1:0]       y_q, y_d;
  logic [1:0]          k_q, k_d;
  logic [AW-1:0]       cur_idx_q, cur_idx_d;
  logic [CW-1:0]       cur_col_q, cur_col_d;
  logic [RW-1:0]       cur_row_q, cur_row_d;
  logic [StepsW-1:0]   gens_q, gens_d, res_q, res_d;
  logic                out_valid_q, out_valid_d;

  // memory ports
  logic          st_we, st_wdata, st_rdata;
  logic [AW-1:0] st_waddr;
  logic          q_we;
  logic [QW-1:0] q_wdata, q_rdata;

  // neighbor of the current cell
  logic          nb_ok, nb_tree;
  logic [AW-1:0] nb_idx;
  logic [CW-1:0] nb_col;
  logic [RW-1:0] nb_row;
  logic [8:0]    cur_col9, cur_row9, w_cl, h_cl;
  logic          in_xfer, out_slot;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign burn_steps_o = res_q;
  assign in_xfer      = in_valid_i & in_ready_o;
  assign out_slot     = !out_valid_q || out_ready_i;

  assign cur_col9 = 9'(cur_col_q);
  assign cur_row9 = 9'(cur_row_q);

  // clamp dimensions to 1..MAX
  always_comb begin
    w_cl = 9'(cfg_w_q);
    if (w_cl == 9'd0) w_cl = 9'd1;
    else if (w_cl > MaxW9) w_cl = MaxW9;
    h_cl = 9'(cfg_h_q);
    if (h_cl == 9'd0) h_cl = 9'd1;
    else if (h_cl > MaxH9) h_cl = MaxH9;
  end

  // neighbor address and bounds
  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_idx_q;
    nb_col = cur_col_q;
    nb_row = cur_row_q;
    unique case (k_q)
      NB_RIGHT: begin
        nb_ok  = (cur_col9 + 9'd1) < w_q;
        nb_idx = cur_idx_q + AW'(h_q);
        nb_col = cur_col_q + CW'(1);
      end
      NB_LEFT: begin
        nb_ok  = cur_col9 != 9'd0;
        nb_idx = cur_idx_q - AW'(h_q);
        nb_col = cur_col_q - CW'(1);
      end
      NB_DOWN: begin
        nb_ok  = (cur_row9 + 9'd1) < h_q;
        nb_idx = cur_idx_q + AW'(1);
        nb_row = cur_row_q + RW'(1);
      end
      NB_UP: begin
        nb_ok  = cur_row9 != 9'd0;
        nb_idx = cur_idx_q - AW'(1);
        nb_row = cur_row_q - RW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // cells past the fill count were never loaded in this load
  assign nb_tree = st_rdata && ({1'b0, nb_idx} < fill_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer && last_cell_i) state_d = S_INIT;
      S_INIT:  if ((9'(y_q) + 9'd1) == h_q) state_d = S_POP;
      S_POP:   state_d = S_CUR;
      S_CUR:   state_d = S_NBRD;
      S_NBRD: begin
        if (nb_ok) state_d = S_NBCHK;
        else if (k_q == NB_UP) state_d = S_LVL;
      end
      S_NBCHK: state_d = (k_q == NB_UP) ? S_LVL : S_NBRD;
      S_LVL: begin
        if (head_q == tail_q) state_d = S_DONE;
        else state_d = S_POP;
      end
      S_DONE:  if (out_slot) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cfg_w_d     = cfg_w_q;
    cfg_h_d     = cfg_h_q;
    w_d         = w_q;
    h_d         = h_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    head_d      = head_q;
    tail_d      = tail_q;
    lvl_d       = lvl_q;
    y_d         = y_q;
    k_d         = k_q;
    cur_idx_d   = cur_idx_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    gens_d      = gens_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    st_we       = 1'b0;
    st_waddr    = nb_idx;
    st_wdata    = 1'b0;
    q_we        = 1'b0;
    q_wdata     = {nb_idx, nb_col, nb_row};

    // register writes
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_GRID_WIDTH) cfg_w_d = cfg_data_i;
      if (cfg_index_i == REG_GRID_HEIGHT) cfg_h_d = cfg_data_i;
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (pos_q < CellsL) begin
            st_we    = 1'b1;
            st_waddr = pos_q[AW-1:0];
            st_wdata = cell_is_tree_i;
            pos_d    = pos_q + LPW'(1);
          end
          if (last_cell_i) begin
            fill_d = (pos_q < CellsL) ? pos_q + LPW'(1) : pos_q;
            pos_d  = '0;
            w_d    = w_cl;
            h_d    = h_cl;
            head_d = '0;
            tail_d = '0;
            y_d    = '0;
            gens_d = '0;
          end
        end
      end
      // light column 0
      S_INIT: begin
        st_we    = 1'b1;
        st_waddr = AW'(y_q);
        q_we     = 1'b1;
        q_wdata  = {AW'(y_q), CW'(0), y_q};
        tail_d   = tail_q + LPW'(1);
        y_d      = y_q + RW'(1);
        lvl_d    = tail_q + LPW'(1);
      end
      S_POP: head_d = head_q + LPW'(1);
      S_CUR: begin
        {cur_idx_d, cur_col_d, cur_row_d} = q_rdata;
        k_d = NB_RIGHT;
      end
      S_NBRD: if (!nb_ok) k_d = k_q + 2'd1;
      S_NBCHK: begin
        if (nb_tree) begin
          st_we  = 1'b1;
          q_we   = 1'b1;
          tail_d = tail_q + LPW'(1);
        end
        k_d = k_q + 2'd1;
      end
      // close a generation when its last cell is done
      S_LVL: begin
        if (head_q == lvl_q) begin
          if ((tail_q != lvl_q) && (gens_q != STEPS_MAX)) gens_d = gens_q + StepsW'(1);
          lvl_d = tail_q;
        end
      end
      S_DONE: begin
        if (out_slot) begin
          res_d       = gens_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_w_q     <= 7'd30;
      cfg_h_q     <= 7'd40;
      pos_q       <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      lvl_q       <= '0;
      y_q         <= '0;
      k_q         <= '0;
      gens_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_w_q     <= cfg_w_d;
      cfg_h_q     <= cfg_h_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      lvl_q       <= lvl_d;
      y_q         <= y_d;
      k_q         <= k_d;
      gens_q      <= gens_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    h_q       <= h_d;
    cur_idx_q <= cur_idx_d;
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    res_q     <= res_d;
  end

  // tree store: 1 = unburned tree
  gfb_ram #(.DEPTH(Cells), .WIDTH(1)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (nb_idx),
    .rdata_o (st_rdata)
  );

  // burn queue of {index, column, row}
  gfb_ram #(.DEPTH(Cells), .WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q[AW-1:0]),
    .wdata_i (q_wdata),
    .raddr_i (head_q[AW-1:0]),
    .rdata_o (q_rdata)
  );

  `GFB_ASSERT_IMP(a_head_le_tail, 1'b1, head_q <= tail_q, "queue head passed tail")
  `GFB_ASSERT_IMP(a_pop_nonempty, state_q == S_POP, head_q < tail_q, "pop from empty queue")
  `GFB_ASSERT_IMP(a_done_drained, state_q == S_DONE, head_q == tail_q, "burn ended early")
  `GFB_ASSERT_NXT(a_last_starts, in_xfer && last_cell_i, state_q == S_INIT,
                  "last cell did not start burn")

endmodule

FILE: rtl/gfb_ram.sv
module gfb_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/grid_fire_burnout_steps_core_test.sv
`timescale 1ns / 1ps

module grid_fire_burnout_steps_core_test;
  import gfb_pkg::*;

  localparam int MaxW = 64;
  localparam int MaxH = 64;
  localparam int NumCells = MaxW * MaxH;

  typedef struct packed {
    logic tree;
    logic last;
  } cell_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_GRID_WIDTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cell_is_tree_i = 1'b0;
  logic last_cell_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StepsW-1:0] burn_steps_o;

  grid_fire_burnout_steps_core #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cell_is_tree_i, .last_cell_i,
    .out_valid_o, .out_ready_i, .burn_steps_o
  );

  // predictor state
  logic [6:0] width_reg = 7'd30;
  logic [6:0] height_reg = 7'd40;
  logic [1:0] forest [NumCells];
  int unsigned fill_pos = 0;

  cell_item_t pending_cells[$];
  logic [StepsW-1:0] expected_steps[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned results_seen = 0;
  int unsigned cells_sent = 0;
  bit failed = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [6:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // level-synchronous flood from column zero; returns generations that lit trees
  function automatic logic [StepsW-1:0] spread_generations();
    int unsigned w, h, head, tail, level_end, gens, idx, x, r;
    int unsigned fire_q[$];
    int unsigned nb[$];
    w = clamp_dim(width_reg, MaxW);
    h = clamp_dim(height_reg, MaxH);
    gens = 0;
    for (int y = 0; y < h; y++) begin
      forest[y] = 2'd2;
      fire_q.push_back(y);
    end
    head = 0;
    level_end = h;
    while (head < fire_q.size()) begin
      idx = fire_q[head];
      head++;
      x = idx / h;
      r = idx % h;
      forest[idx] = 2'd0;
      nb.delete();
      if (x + 1 < w) nb.push_back(idx + h);
      if (x > 0) nb.push_back(idx - h);
      if (r + 1 < h) nb.push_back(idx + 1);
      if (r > 0) nb.push_back(idx - 1);
      foreach (nb[k]) begin
        if (forest[nb[k]] == 2'd1) begin
          forest[nb[k]] = 2'd2;
          fire_q.push_back(nb[k]);
        end
      end
      if (head == level_end) begin
        if (fire_q.size() > level_end && gens < STEPS_MAX) gens++;
        level_end = fire_q.size();
      end
    end
    return gens[StepsW-1:0];
  endfunction

  // predict on each accepted cell
  function automatic void accept_cell(cell_item_t c);
    if (fill_pos == 0) begin
      for (int i = 0; i < NumCells; i++) forest[i] = 2'd0;
    end
    if (fill_pos < NumCells) begin
      forest[fill_pos] = c.tree ? 2'd1 : 2'd0;
      fill_pos++;
    end
    if (c.last) begin
      expected_steps.push_back(spread_generations());
      fill_pos = 0;
    end
  endfunction

  // queue one grid of cells; density sets tree probability in percent
  task automatic queue_grid(int unsigned ncells, int unsigned density);
    cell_item_t c;
    for (int unsigned i = 0; i < ncells; i++) begin
      c.tree = ($urandom_range(99) < density);
      c.last = (i == ncells - 1);
      pending_cells.push_back(c);
    end
  endtask

  // driver: cell transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accept_cell('{tree: cell_is_tree_i, last: last_cell_i});
        cells_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          cell_is_tree_i <= pending_cells[0].tree;
          last_cell_i <= pending_cells[0].last;
          void'(pending_cells.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: result transfers and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result burn_steps=%0d", $time, burn_steps_o);
          failed = 1'b1;
        end else begin
          if (burn_steps_o !== expected_steps[0]) begin
            $display("%0t: burn_steps expected %0d actual %0d", $time,
                     expected_steps[0], burn_steps_o);
            failed = 1'b1;
          end
          void'(expected_steps.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic drain();
    while (pending_cells.size() > 0 || in_valid_i || expected_steps.size() > 0)
      @(posedge clk_i);
    // a cell without last_cell may still be settling
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic set_dims(logic [6:0] w, logic [6:0] h);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
  endtask

  // random phase: mostly small grids, some exact fits, some short or long loads
  task automatic random_grids(int unsigned ncells_total);
    int unsigned w, h, n, sent;
    sent = 0;
    while (sent < ncells_total) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(0, 127);
        h = $urandom_range(0, 3);
      end
      set_dims(7'(w), 7'(h));
      for (int g = 0; g < 4; g++) begin
        if (sent >= ncells_total) break;
        n = clamp_dim(7'(w), MaxW) * clamp_dim(7'(h), MaxH);
        case ($urandom_range(5))
          0: n = $urandom_range(1, n);
          1: n = n + $urandom_range(1, 6);
          default: ;
        endcase
        if (n > 120) n = $urandom_range(1, 120);
        queue_grid(n, $urandom_range(30, 100));
        sent += n;
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NumCells; i++) forest[i] = 2'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset dimensions are large, so use small grids first
    set_dims(7'd1, 7'd1);
    queue_grid(1, 0);
    queue_grid(2, 100);          // extra cell beyond the grid
    drain();
    set_dims(7'd4, 7'd3);
    queue_grid(12, 100);         // full forest
    queue_grid(12, 0);           // empty forest
    queue_grid(5, 100);          // short load
    drain();
    set_dims(7'd0, 7'd0);        // zero read as one
    queue_grid(1, 100);
    drain();
    set_dims(7'd127, 7'd1);      // width clamps to maximum
    queue_grid(64, 100);
    drain();
    set_dims(7'd2, 7'd127);      // height clamps to maximum
    queue_grid(128, 100);
    drain();
    set_dims(7'd64, 7'd64);      // largest grid, only the first columns loaded
    queue_grid(300, 100);
    drain();
    // small square grid
    set_dims(7'd3, 7'd3);
    queue_grid(9, 100);
    drain();

    // random phases with varied idling
    random_grids(300);
    send_idle_pct = 71;
    random_grids(250);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    random_grids(250);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    random_grids(200);

    // pressure: long receiver hold-off while grids keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_dims(7'd2, 7'd2);
    hold_off_cycles = 400;
    for (int g = 0; g < 8; g++) queue_grid(4, 70);
    drain();
    random_grids(100);

    drain();
    repeat (50) @(posedge clk_i);
    if (!failed && expected_steps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
